### src/tmsr_pkg.sv
package tmsr_pkg;

    localparam int MAP_BYTES_DEF   = 8192;
    localparam int LINE_PIXELS_DEF = 320;
    localparam int PAT_BYTES       = 2048;
    localparam int PAT_AW          = 11;
    localparam int GROUP_PIXELS    = 16;

    // action codes of an input beat
    localparam logic [2:0] ACT_MAP_WR  = 3'd0;
    localparam logic [2:0] ACT_PAT_WR  = 3'd1;
    localparam logic [2:0] ACT_XLAT_WR = 3'd2;
    localparam logic [2:0] ACT_PAL_WR  = 3'd3;
    localparam logic [2:0] ACT_RENDER  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_SCROLL_X  = 2'd0;
    localparam logic [1:0] CFG_SCROLL_Y  = 2'd1;
    localparam logic [1:0] CFG_MAP_WIDTH = 2'd2;

    localparam logic [15:0] MAP_WIDTH_RESET = 16'd128;

    typedef struct packed {
        logic [2:0]  action;
        logic [12:0] address;
        logic [15:0] write_data;
        logic [7:0]  line;
        logic [4:0]  group;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [8:0]  screen_column;
        logic        last_of_group;
    } res_t;

    typedef enum logic [2:0] {
        TK_PIXEL,
        TK_MAP_WR,
        TK_PAT_WR,
        TK_XLAT_WR,
        TK_PAL_WR
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [12:0] addr;
        logic [15:0] wdata;
        logic [8:0]  col;
        logic        last;
    } tok_t;

endpackage

### src/tile_map_scanline_renderer.sv
// Channel   | Ports                        | Handshake
// ----------+------------------------------+-----------------------------------------
// command   | start, busy, cmd             | beat taken at clk edge with start && !busy
// result    | strobe, result               | one beat per cycle with strobe high
// config    | wr_en, wr_index, wr_data     | register written at clk edge with wr_en
//
// A render beat whose group ends inside the line yields 16 pixels on consecutive
// cycles; a write beat occupies one issue slot. The pixel sequencer sets the rate:
// busy is high while it still has pixels of the current group to issue, so the next
// beat is taken in the cycle of the sixteenth issue and groups stream without a gap.
// Reset clears valid bits, the sequencer and the scroll registers, and sets the map
// width register to 128 and the tile translator to identity. The receiver cannot
// stall; nothing waits.
module tile_map_scanline_renderer #(
    parameter int MAP_BYTES   = tmsr_pkg::MAP_BYTES_DEF,
    parameter int LINE_PIXELS = tmsr_pkg::LINE_PIXELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tmsr_pkg::cmd_t cmd,
    output logic           strobe,
    output tmsr_pkg::res_t result,
    input  logic           wr_en,
    input  logic [1:0]     wr_index,
    input  logic [15:0]    wr_data
);
    import tmsr_pkg::*;

    localparam int MAP_AW = $clog2(MAP_BYTES);
    localparam logic [10:0] LINE_LIM = 11'(LINE_PIXELS);

    // configuration
    logic [14:0] scroll_x_reg;
    logic [14:0] scroll_y_reg;
    logic [15:0] map_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_x_reg  <= '0;
            scroll_y_reg  <= '0;
            map_width_reg <= MAP_WIDTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_SCROLL_X:  scroll_x_reg  <= wr_data[14:0];
                CFG_SCROLL_Y:  scroll_y_reg  <= wr_data[14:0];
                CFG_MAP_WIDTH: map_width_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- issue sequencer ----------------
    logic        gen_valid_reg, gen_valid_next;
    tok_kind_t   gen_kind_reg, gen_kind_next;
    logic [3:0]  gen_cnt_reg, gen_cnt_next;
    logic [12:0] gen_addr_reg;
    logic [15:0] gen_wdata_reg;
    logic [7:0]  gen_line_reg;
    logic [4:0]  gen_group_reg;

    logic        gen_last;
    logic        accept;
    logic        cmd_known;
    tok_kind_t   cmd_kind;
    logic [10:0] group_end;

    assign gen_last = (gen_kind_reg != TK_PIXEL) || (gen_cnt_reg == 4'hF);
    assign busy     = gen_valid_reg && !gen_last;
    assign accept   = start && !busy;
    assign group_end = {2'b00, cmd.group, 4'b0000} + 11'(GROUP_PIXELS);

    always_comb
    begin
        cmd_known = 1'b1;
        cmd_kind  = TK_PIXEL;
        unique case (cmd.action)
            ACT_MAP_WR:  cmd_kind = TK_MAP_WR;
            ACT_PAT_WR:  cmd_kind = TK_PAT_WR;
            ACT_XLAT_WR: cmd_kind = TK_XLAT_WR;
            ACT_PAL_WR:  cmd_kind = TK_PAL_WR;
            ACT_RENDER:  cmd_known = (group_end <= LINE_LIM);
            default:     cmd_known = 1'b0;
        endcase
    end

    always_comb
    begin
        gen_valid_next = gen_valid_reg;
        gen_kind_next  = gen_kind_reg;
        gen_cnt_next   = gen_cnt_reg;
        if (accept)
        begin
            gen_valid_next = cmd_known;
            gen_kind_next  = cmd_kind;
            gen_cnt_next   = 4'h0;
        end
        else if (gen_valid_reg && gen_last)
        begin
            gen_valid_next = 1'b0;
        end
        else if (gen_valid_reg)
        begin
            gen_cnt_next = gen_cnt_reg + 4'h1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_valid_reg <= 1'b0;
            gen_kind_reg  <= TK_PIXEL;
            gen_cnt_reg   <= 4'h0;
        end
        else
        begin
            gen_valid_reg <= gen_valid_next;
            gen_kind_reg  <= gen_kind_next;
            gen_cnt_reg   <= gen_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gen_addr_reg  <= cmd.address;
            gen_wdata_reg <= cmd.write_data;
            gen_line_reg  <= cmd.line;
            gen_group_reg <= cmd.group;
        end
    end

    // issue slot: screen x and map coordinates
    logic [8:0]  issue_sx;
    logic [15:0] issue_mx;
    logic [15:0] issue_my;
    tok_t        issue_tok;

    assign issue_sx = {gen_group_reg, gen_cnt_reg};
    assign issue_mx = {1'b0, scroll_x_reg} + {7'b0, issue_sx};
    assign issue_my = {1'b0, scroll_y_reg} + {8'b0, gen_line_reg};

    always_comb
    begin
        issue_tok.kind  = gen_kind_reg;
        issue_tok.addr  = gen_addr_reg;
        issue_tok.wdata = gen_wdata_reg;
        issue_tok.col   = issue_sx;
        issue_tok.last  = (gen_cnt_reg == 4'hF);
    end

    // ---------------- pipeline ----------------
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    tok_t        s1_tok_reg, s2_tok_reg, s3_tok_reg, s4_tok_reg, s5_tok_reg, s6_tok_reg;
    logic [15:0] s1_mx_reg, s1_my_reg;
    logic [27:0] s2_prod_reg;
    logic [11:0] s2_col_reg;
    logic [7:0]  s2_sub_reg, s3_sub_reg, s4_sub_reg;
    logic [MAP_AW-1:0] s3_maddr_reg;
    logic        s3_par_reg, s4_par_reg;
    logic [PAT_AW-1:0] s5_paddr_reg;
    logic        s5_hi_reg, s6_hi_reg;
    logic [7:0]  map_rd_reg;
    logic [7:0]  pat_rd_reg;
    res_t        s7_res_reg;

    logic [7:0]  map_mem [MAP_BYTES];
    logic [7:0]  pat_mem [PAT_BYTES];
    logic [3:0]  xlat_reg [16];
    logic [15:0] pal_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= gen_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg && (s6_tok_reg.kind == TK_PIXEL);
        end
    end

    // stage 1: map coordinates
    always_ff @(posedge clk)
    begin
        s1_tok_reg <= issue_tok;
        s1_mx_reg  <= issue_mx;
        s1_my_reg  <= issue_my;
    end

    // stage 2: tile row times stride
    always_ff @(posedge clk)
    begin
        s2_tok_reg  <= s1_tok_reg;
        s2_prod_reg <= s1_my_reg[15:4] * map_width_reg;
        s2_col_reg  <= s1_mx_reg[15:4];
        s2_sub_reg  <= {s1_my_reg[3:0], s1_mx_reg[3:0]};
    end

    // stage 3: tile index to map byte address
    logic [28:0] s2_index;
    assign s2_index = {1'b0, s2_prod_reg} + {17'b0, s2_col_reg};

    always_ff @(posedge clk)
    begin
        s3_tok_reg <= s2_tok_reg;
        s3_sub_reg <= s2_sub_reg;
        s3_par_reg <= s2_index[0];
        if (s2_tok_reg.kind == TK_MAP_WR)
        begin
            s3_maddr_reg <= MAP_AW'(s2_tok_reg.addr);
        end
        else
        begin
            s3_maddr_reg <= s2_index[MAP_AW:1];
        end
    end

    // stage 4: map store access, writes land in order with the reads
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && (s3_tok_reg.kind == TK_MAP_WR))
        begin
            map_mem[s3_maddr_reg] <= s3_tok_reg.wdata[7:0];
        end
        map_rd_reg <= map_mem[s3_maddr_reg];
        s4_tok_reg <= s3_tok_reg;
        s4_sub_reg <= s3_sub_reg;
        s4_par_reg <= s3_par_reg;
    end

    // stage 5: tile nibble through the translator
    logic [3:0] s4_tile;
    logic [3:0] s4_pat;
    assign s4_tile = s4_par_reg ? map_rd_reg[7:4] : map_rd_reg[3:0];
    assign s4_pat  = xlat_reg[s4_tile];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                xlat_reg[i] <= 4'(i);
            end
        end
        else if (s4_valid_reg && (s4_tok_reg.kind == TK_XLAT_WR))
        begin
            xlat_reg[s4_tok_reg.addr[3:0]] <= s4_tok_reg.wdata[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s5_tok_reg <= s4_tok_reg;
        s5_hi_reg  <= s4_sub_reg[0];
        if (s4_tok_reg.kind == TK_PAT_WR)
        begin
            s5_paddr_reg <= s4_tok_reg.addr[PAT_AW-1:0];
        end
        else
        begin
            s5_paddr_reg <= {s4_pat, s4_sub_reg[7:4], s4_sub_reg[3:1]};
        end
    end

    // stage 6: pattern store access
    always_ff @(posedge clk)
    begin
        if (s5_valid_reg && (s5_tok_reg.kind == TK_PAT_WR))
        begin
            pat_mem[s5_paddr_reg] <= s5_tok_reg.wdata[7:0];
        end
        pat_rd_reg <= pat_mem[s5_paddr_reg];
        s6_tok_reg <= s5_tok_reg;
        s6_hi_reg  <= s5_hi_reg;
    end

    // stage 7: palette lookup into the output register
    logic [3:0] s6_nib;
    assign s6_nib = s6_hi_reg ? pat_rd_reg[7:4] : pat_rd_reg[3:0];

    always_ff @(posedge clk)
    begin
        if (s6_valid_reg && (s6_tok_reg.kind == TK_PAL_WR))
        begin
            pal_reg[s6_tok_reg.addr[3:0]] <= s6_tok_reg.wdata;
        end
        s7_res_reg.pixel_color   <= pal_reg[s6_nib];
        s7_res_reg.screen_column <= s6_tok_reg.col;
        s7_res_reg.last_of_group <= s6_tok_reg.last;
    end

    assign strobe = s7_valid_reg;
    assign result = s7_res_reg;

    // ---------------- assertions ----------------
    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_of_group |-> result.screen_column[3:0] == 4'hF)
        else $error("last pixel of a group not on a group boundary");

    a_group_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_of_group |=>
            strobe && (result.screen_column == 9'($past(result.screen_column) + 9'd1)))
        else $error("pixels of a group not emitted on consecutive cycles");

    a_busy_render: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> gen_valid_reg && (gen_kind_reg == TK_PIXEL) && (gen_cnt_reg != 4'hF))
        else $error("busy outside a render issue");

    a_issue_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !start |=> gen_valid_reg && (gen_cnt_reg == 4'($past(gen_cnt_reg) + 4'h1)))
        else $error("pixel sequencer skipped or held a pixel");

endmodule
